### rtl/core/nhfp_pkg.sv
// Shared types, constants and name table for the news header field parser.
`timescale 1ns / 1ps
package nhfp_pkg;

   localparam int unsigned DEF_MAX_HEADER_BYTES = 4096;
   localparam int unsigned NAME_COUNT = 23;
   localparam int unsigned NAME_CHARS = 16;
   localparam int unsigned FIELD_W = 5;
   localparam int unsigned POS_W = 5;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned HLEN_W = 13;
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 1;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ALL_FIELDS   = 1'd0,
      REG_UPPER_D_ONLY = 1'd1
   } csr_reg_type;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_VT  = 8'h0b;
   localparam logic [7:0] CH_FF  = 8'h0c;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_UPPER_D = 8'h44;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_OFFSET : c;
   endfunction

   // lowercase names, colon included, right-aligned
   function automatic logic [8*NAME_CHARS-1:0] name_text(int unsigned idx);
      logic [8*NAME_CHARS-1:0] t;
      case (idx)
         0:       t = "approved:";
         1:       t = "back-references:";
         2:       t = "control:";
         3:       t = "comment-to:";
         4:       t = "date:";
         5:       t = "date-received:";
         6:       t = "distribution:";
         7:       t = "from:";
         8:       t = "followup-to:";
         9:       t = "keywords:";
         10:      t = "lines:";
         11:      t = "message-id:";
         12:      t = "newsgroups:";
         13:      t = "organization:";
         14:      t = "originator:";
         15:      t = "path:";
         16:      t = "references:";
         17:      t = "reply-to:";
         18:      t = "subject:";
         19:      t = "sender:";
         20:      t = "summary:";
         21:      t = "title:";
         22:      t = "xref:";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [POS_W-1:0] name_len(int unsigned idx);
      logic [POS_W-1:0] l;
      case (idx)
         0:       l = 5'd9;
         1:       l = 5'd16;
         2:       l = 5'd8;
         3:       l = 5'd11;
         4:       l = 5'd5;
         5:       l = 5'd14;
         6:       l = 5'd13;
         7:       l = 5'd5;
         8:       l = 5'd12;
         9:       l = 5'd9;
         10:      l = 5'd6;
         11:      l = 5'd11;
         12:      l = 5'd11;
         13:      l = 5'd13;
         14:      l = 5'd11;
         15:      l = 5'd5;
         16:      l = 5'd11;
         17:      l = 5'd9;
         18:      l = 5'd8;
         19:      l = 5'd7;
         20:      l = 5'd8;
         21:      l = 5'd6;
         22:      l = 5'd5;
         default: l = '0;
      endcase
      return l;
   endfunction

   // Title shares the Subject id
   function automatic logic [FIELD_W-1:0] name_id(int unsigned idx);
      logic [FIELD_W-1:0] f;
      if (idx <= 20) begin
         f = FIELD_W'(idx + 1);
      end else if (idx == 21) begin
         f = 5'd19;
      end else begin
         f = 5'd22;
      end
      return f;
   endfunction

   localparam logic [NAME_COUNT-1:0] NAME_EXTENDED = 23'b001_0000_1110_1011_0110_0001;

   function automatic logic [7:0] name_char(int unsigned idx, logic [POS_W-1:0] pos);
      logic [8*NAME_CHARS-1:0] t;
      logic [3:0] sh;
      t = name_text(idx);
      sh = 4'(name_len(idx) - pos - 5'd1);
      return t[8*sh +: 8];
   endfunction

endpackage

### rtl/core/nhfp_if.sv
// Channel interfaces: header bytes in, parsed results out, register writes.
`timescale 1ns / 1ps

interface nhfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;
   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface nhfp_rsp_if #(parameter int unsigned LEN_W = 13);
   logic             valid;
   logic             ready;
   logic [1:0]       item_kind;
   logic [4:0]       field_id;
   logic [7:0]       value_byte;
   logic [LEN_W-1:0] header_length;
   logic             blank_line_found;
   modport source (output valid, output item_kind, output field_id, output value_byte,
                   output header_length, output blank_line_found, input ready);
   modport sink (input valid, input item_kind, input field_id, input value_byte,
                 input header_length, input blank_line_found, output ready);
endinterface

interface nhfp_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] addr;
   logic [0:0] wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

### rtl/core/nhfp_outq.sv
// Four-entry result queue taking up to two results a cycle, one out a cycle while the sink is ready.
`timescale 1ns / 1ps
module nhfp_outq
   import nhfp_pkg::*;
#(
   parameter int unsigned LEN_W = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_cnt,
   input  logic [KIND_W+FIELD_W+8+LEN_W:0] push_d0,
   input  logic [KIND_W+FIELD_W+8+LEN_W:0] push_d1,
   output logic                room,
   nhfp_rsp_if.source          rsp_ch
);

   localparam int unsigned RES_W = KIND_W + FIELD_W + 8 + LEN_W + 1;
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [RES_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   logic [RES_W-1:0] head;

   assign pop = rsp_ch.valid && rsp_ch.ready;
   assign room = cnt_ff <= CNT_W'(QUEUE_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_d0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push_d1;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign rsp_ch.valid = cnt_ff != '0;
   assign {rsp_ch.item_kind, rsp_ch.field_id, rsp_ch.value_byte,
           rsp_ch.header_length, rsp_ch.blank_line_found} = head;

endmodule

### rtl/core/nhfp_parser.sv
// Input register, parse state and the per-byte name match and folding logic.
`timescale 1ns / 1ps
module nhfp_parser
   import nhfp_pkg::*;
#(
   parameter int unsigned MAX_HEADER_BYTES = DEF_MAX_HEADER_BYTES,
   parameter int unsigned LEN_W = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                all_fields,
   input  logic                upper_d_only,
   nhfp_req_if.sink            req_ch,
   input  logic                room,
   output logic [1:0]          push_cnt,
   output logic [KIND_W+FIELD_W+8+HLEN_W:0] push_d0,
   output logic [KIND_W+FIELD_W+8+HLEN_W:0] push_d1
);

   localparam int unsigned RES_W = KIND_W + FIELD_W + 8 + HLEN_W + 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_HEADER_BYTES);

   typedef enum logic [4:0] {
      PH_START   = 5'b00001,
      PH_NAME    = 5'b00010,
      PH_BLANKS  = 5'b00100,
      PH_VALUE   = 5'b01000,
      PH_NEWLINE = 5'b10000
   } phase_type;

   function automatic logic [RES_W-1:0] pack_res(kind_type k, logic [FIELD_W-1:0] f,
                                                 logic [7:0] v, logic [HLEN_W-1:0] l,
                                                 logic bl);
      return {k, f, v, l, bl};
   endfunction

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_eod_ff;
   logic                  proc;

   phase_type             phase_ff, phase_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [NAME_COUNT-1:0] mask_ff, mask_in;
   logic [FIELD_W-1:0]    field_ff, field_in;
   logic                  open_ff, open_in;
   logic                  nl_ff, nl_in;
   logic                  sp_ff, sp_in;
   logic [LEN_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]            n_out;
   logic [RES_W-1:0]      res0, res1;

   assign proc = in_valid_ff && room;
   assign req_ch.ready = !in_valid_ff || proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_eod_ff <= req_ch.end_of_data;
      end
   end

   always_comb begin
      logic [NAME_COUNT-1:0] keep;
      logic [FIELD_W-1:0]    found;
      logic                  done;
      logic                  blank;
      logic                  lf;
      logic [7:0]            lb;
      logic [LEN_W-1:0]      cnt_inc;
      logic [RES_W-1:0]      r;

      phase_in = phase_ff;
      pos_in = pos_ff;
      mask_in = mask_ff;
      field_in = field_ff;
      open_in = open_ff;
      nl_in = nl_ff;
      sp_in = sp_ff;
      cnt_in = cnt_ff;
      n_out = 2'd0;
      res0 = '0;
      res1 = '0;
      keep = '0;
      found = '0;
      done = 1'b0;
      r = '0;
      blank = is_blank(in_byte_ff);
      lf = in_byte_ff == CH_LF;
      lb = to_lower(in_byte_ff);
      cnt_inc = (cnt_ff < LEN_MAX) ? cnt_ff + LEN_W'(1) : cnt_ff;

      if (in_eod_ff || in_byte_ff == CH_NUL) begin
         if (open_ff) begin
            res0 = pack_res(KIND_END, field_ff, 8'd0, '0, 1'b0);
            res1 = pack_res(KIND_DONE, '0, 8'd0, HLEN_W'(cnt_ff), 1'b0);
            n_out = 2'd2;
         end else begin
            res0 = pack_res(KIND_DONE, '0, 8'd0, HLEN_W'(cnt_ff), 1'b0);
            n_out = 2'd1;
         end
         phase_in = PH_START;
         pos_in = '0;
         mask_in = '1;
         field_in = '0;
         open_in = 1'b0;
         nl_in = 1'b0;
         sp_in = 1'b0;
         cnt_in = '0;
      end else begin
         cnt_in = cnt_inc;

         if (phase_in == PH_NEWLINE) begin
            nl_in = 1'b0;
            if (blank) begin
               // continuation line: fold the newline into a space
               if (open_in) begin
                  res0 = pack_res(KIND_DATA, field_in, CH_SP, '0, 1'b0);
                  res1 = pack_res(KIND_DATA, field_in, in_byte_ff, '0, 1'b0);
                  n_out = 2'd2;
               end
               phase_in = PH_VALUE;
               done = 1'b1;
            end else begin
               if (open_in) begin
                  res0 = pack_res(KIND_END, field_in, 8'd0, '0, 1'b0);
                  n_out = 2'd1;
               end
               open_in = 1'b0;
               field_in = '0;
               phase_in = PH_START;
            end
         end

         if (!done && phase_in == PH_START) begin
            if (sp_in) begin
               sp_in = 1'b0;
               if (in_byte_ff == CH_SP) begin
                  done = 1'b1;
               end else begin
                  open_in = 1'b0;
                  phase_in = PH_VALUE;
               end
            end else if (lf) begin
               r = pack_res(KIND_DONE, '0, 8'd0, HLEN_W'(cnt_inc), 1'b1);
               if (n_out == 2'd0) begin
                  res0 = r;
               end else begin
                  res1 = r;
               end
               n_out = n_out + 2'd1;
               phase_in = PH_START;
               pos_in = '0;
               mask_in = '1;
               field_in = '0;
               open_in = 1'b0;
               nl_in = 1'b0;
               sp_in = 1'b0;
               cnt_in = '0;
               done = 1'b1;
            end else if (in_byte_ff == CH_SP) begin
               sp_in = 1'b1;
               done = 1'b1;
            end else begin
               mask_in = all_fields ? '1 : ~NAME_EXTENDED;
               if (upper_d_only && in_byte_ff != CH_UPPER_D) begin
                  mask_in = '0;
               end
               pos_in = '0;
               phase_in = PH_NAME;
            end
         end

         if (!done && phase_in == PH_NAME) begin
            for (int unsigned i = 0; i < NAME_COUNT; i++) begin
               if (mask_in[i]) begin
                  if (pos_in < name_len(i)) begin
                     if (lb == name_char(i, pos_in)) begin
                        keep[i] = 1'b1;
                     end
                  end else if (pos_in == name_len(i)) begin
                     if (blank || lf) begin
                        found = name_id(i);
                     end
                  end
               end
            end
            if (found != '0) begin
               open_in = 1'b0;
               if (lf) begin
                  field_in = '0;
                  nl_in = 1'b1;
                  phase_in = PH_NEWLINE;
               end else begin
                  field_in = found;
                  phase_in = PH_BLANKS;
               end
               done = 1'b1;
            end else if (keep != '0) begin
               mask_in = keep;
               pos_in = pos_in + POS_W'(1);
               done = 1'b1;
            end else begin
               mask_in = '0;
               open_in = 1'b0;
               phase_in = PH_VALUE;
            end
         end

         if (!done && phase_in == PH_BLANKS) begin
            done = 1'b1;
            if (lf) begin
               field_in = '0;
               nl_in = 1'b1;
               phase_in = PH_NEWLINE;
            end else if (!blank) begin
               open_in = 1'b1;
               res0 = pack_res(KIND_DATA, field_in, in_byte_ff, '0, 1'b0);
               n_out = 2'd1;
               phase_in = PH_VALUE;
            end
         end

         if (!done) begin
            if (lf) begin
               nl_in = 1'b1;
               phase_in = PH_NEWLINE;
            end else if (open_in) begin
               res0 = pack_res(KIND_DATA, field_in, in_byte_ff, '0, 1'b0);
               n_out = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff <= '0;
         mask_ff <= '1;
         field_ff <= '0;
         open_ff <= 1'b0;
         nl_ff <= 1'b0;
         sp_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (proc) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         mask_ff <= mask_in;
         field_ff <= field_in;
         open_ff <= open_in;
         nl_ff <= nl_in;
         sp_ff <= sp_in;
         cnt_ff <= cnt_in;
      end
   end

   assign push_cnt = proc ? n_out : 2'd0;
   assign push_d0 = res0;
   assign push_d1 = res1;

endmodule

### rtl/core/news_header_field_parser.sv
// Top level of the news header field parser: register file and channel wiring.
`timescale 1ns / 1ps
//
// channel  dir  handshake     payload
// req_ch   in   valid/ready   data_byte, end_of_data
// rsp_ch   out  valid/ready   item_kind, field_id, value_byte, header_length, blank_line_found
// csr_ch   in   valid/ready   addr, wdata (always ready)
//
// A request is registered, then parsed combinationally into a four-entry result queue.
// One request a cycle while the queue holds two or fewer results; a request that
// makes two results (folded newline, value end before header end) pushes both at
// once, and the output hands them out one after the other. A request passes the input register and then a queue entry.
// Synchronous reset clears parse state and both registers.
module news_header_field_parser
   import nhfp_pkg::*;
#(
   parameter int unsigned MAX_HEADER_BYTES = DEF_MAX_HEADER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   nhfp_req_if.sink    req_ch,
   nhfp_rsp_if.source  rsp_ch,
   nhfp_csr_if.sink    csr_ch
);

   localparam int unsigned LEN_W = $clog2(MAX_HEADER_BYTES + 1);
   localparam int unsigned RES_W = KIND_W + FIELD_W + 8 + HLEN_W + 1;

   logic             all_fields_ff, upper_d_only_ff;
   logic             room;
   logic [1:0]       push_cnt;
   logic [RES_W-1:0] push_d0, push_d1;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         all_fields_ff <= 1'b0;
         upper_d_only_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_reg_type'(csr_ch.addr))
            REG_ALL_FIELDS:   all_fields_ff <= csr_ch.wdata[0];
            REG_UPPER_D_ONLY: upper_d_only_ff <= csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   nhfp_parser #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
      .LEN_W            (LEN_W)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .all_fields   (all_fields_ff),
      .upper_d_only (upper_d_only_ff),
      .req_ch       (req_ch),
      .room         (room),
      .push_cnt     (push_cnt),
      .push_d0      (push_d0),
      .push_d1      (push_d1)
   );

   nhfp_outq #(
      .LEN_W (HLEN_W)
   ) u_outq (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .push_d0  (push_d0),
      .push_d1  (push_d1),
      .room     (room),
      .rsp_ch   (rsp_ch)
   );

endmodule

### sim/tb_news_header_field_parser.sv
// Self-checking testbench for the news header field parser: directed and random headers.
`timescale 1ns / 1ps

module tb_news_header_field_parser;
   import nhfp_pkg::*;

   localparam int unsigned SAT_BYTES   = DEF_MAX_HEADER_BYTES;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned PHASE_BYTES = 250;
   localparam int unsigned LONG_VALUE  = SAT_BYTES + 100;
   localparam int unsigned DRAIN_WAIT  = 8;
   // per random phase: all_fields and upper_d_only settings
   localparam logic [5:0] ALL_SEQ  = 6'b010011;
   localparam logic [5:0] DATE_SEQ = 6'b000110;
   // names that need all_fields
   localparam logic [NAME_COUNT-1:0] EXT_FIELDS = 23'b001_0000_1110_1011_0110_0001;

   typedef enum logic [2:0] {LN_START, LN_NAME, LN_BLANKS, LN_VALUE, LN_FOLD} line_phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  field;
      logic [7:0]  vbyte;
      logic [12:0] hlen;
      logic        blank;
   } parse_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eod;
   } hdr_byte_type;

   string field_names[NAME_COUNT] = '{
      "approved:", "back-references:", "control:", "comment-to:", "date:",
      "date-received:", "distribution:", "from:", "followup-to:", "keywords:",
      "lines:", "message-id:", "newsgroups:", "organization:", "originator:",
      "path:", "references:", "reply-to:", "subject:", "sender:", "summary:",
      "title:", "xref:"};
   logic [4:0] field_ids[NAME_COUNT] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd19, 5'd22};

   class header_field_tracker;
      bit                    all_fields;
      bit                    upper_d_only;
      line_phase_type        phase;
      logic [4:0]            name_pos;
      logic [NAME_COUNT-1:0] live_names;
      logic [4:0]            field;
      bit                    value_live;
      bit                    space_seen;
      logic [12:0]           byte_total;
      parse_result_type      due_results[$];
      int unsigned           errors;

      function new();
         all_fields = 1'b0;
         upper_d_only = 1'b0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         phase = LN_START;
         name_pos = '0;
         live_names = '1;
         field = '0;
         value_live = 1'b0;
         space_seen = 1'b0;
         byte_total = '0;
      endfunction

      function void set_reg(csr_reg_type r, logic v);
         if (r == REG_ALL_FIELDS) begin
            all_fields = v;
         end else begin
            upper_d_only = v;
         end
      endfunction

      function bit is_gap(logic [7:0] c);
         case (c)
            CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function logic [7:0] fold_case(logic [7:0] c);
         return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
      endfunction

      function void add(kind_type k, logic [4:0] f, logic [7:0] v, logic [12:0] l,
                        logic bl);
         parse_result_type r;
         r.kind = k;
         r.field = f;
         r.vbyte = v;
         r.hlen = l;
         r.blank = bl;
         due_results.push_back(r);
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void accept_byte(logic [7:0] b, logic eod);
         logic [NAME_COUNT-1:0] keep;
         logic [4:0]            hit;
         int                    i;
         if (eod || b == CH_NUL) begin
            if (value_live) add(KIND_END, field, '0, '0, 1'b0);
            add(KIND_DONE, '0, '0, byte_total, 1'b0);
            restart();
            return;
         end
         if (byte_total < SAT_BYTES) byte_total++;

         if (phase == LN_FOLD) begin
            if (is_gap(b)) begin
               if (value_live) begin
                  add(KIND_DATA, field, CH_SP, '0, 1'b0);
                  add(KIND_DATA, field, b, '0, 1'b0);
               end
               phase = LN_VALUE;
               return;
            end
            if (value_live) add(KIND_END, field, '0, '0, 1'b0);
            value_live = 1'b0;
            field = '0;
            phase = LN_START;
         end

         if (phase == LN_START) begin
            if (space_seen) begin
               space_seen = 1'b0;
               if (b == CH_SP) return;
               value_live = 1'b0;
               phase = LN_VALUE;
            end else if (b == CH_LF) begin
               add(KIND_DONE, '0, '0, byte_total, 1'b1);
               restart();
               return;
            end else if (b == CH_SP) begin
               space_seen = 1'b1;
               return;
            end else begin
               live_names = all_fields ? '1 : ~EXT_FIELDS;
               if (upper_d_only && b != CH_UPPER_D) live_names = '0;
               name_pos = '0;
               phase = LN_NAME;
            end
         end

         if (phase == LN_NAME) begin
            keep = '0;
            hit = '0;
            for (i = 0; i < NAME_COUNT; i++) begin
               if (live_names[i]) begin
                  if (int'(name_pos) < field_names[i].len()) begin
                     if (fold_case(b) == 8'(field_names[i][name_pos])) keep[i] = 1'b1;
                  end else if (int'(name_pos) == field_names[i].len()) begin
                     if (is_gap(b) || b == CH_LF) hit = field_ids[i];
                  end
               end
            end
            if (hit != '0) begin
               field = hit;
               value_live = 1'b0;
               if (b == CH_LF) begin
                  field = '0;
                  phase = LN_FOLD;
               end else begin
                  phase = LN_BLANKS;
               end
               return;
            end
            if (keep != '0) begin
               live_names = keep;
               name_pos = name_pos + 5'd1;
               return;
            end
            live_names = '0;
            value_live = 1'b0;
            phase = LN_VALUE;
         end

         if (phase == LN_BLANKS) begin
            if (is_gap(b)) return;
            if (b == CH_LF) begin
               field = '0;
               phase = LN_FOLD;
               return;
            end
            value_live = 1'b1;
            add(KIND_DATA, field, b, '0, 1'b0);
            phase = LN_VALUE;
            return;
         end

         if (b == CH_LF) begin
            phase = LN_FOLD;
         end else if (value_live) begin
            add(KIND_DATA, field, b, '0, 1'b0);
         end
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type want;
         if (due_results.size() == 0) begin
            $display("%0t unexpected result: expected none, got %s",
                     $time, $sformatf("kind=%0d field=%0d byte=%02h len=%0d blank=%0d",
                     got.kind, got.field, got.vbyte, got.hlen, got.blank));
            errors++;
            return;
         end
         want = due_results.pop_front();
         if (got !== want) begin
            $display("%0t mismatch: expected kind=%0d field=%0d byte=%02h len=%0d blank=%0d",
                     $time, want.kind, want.field, want.vbyte, want.hlen, want.blank);
            $display("%0t            actual kind=%0d field=%0d byte=%02h len=%0d blank=%0d",
                     $time, got.kind, got.field, got.vbyte, got.hlen, got.blank);
            errors++;
         end
      endfunction

      function void flush_missing();
         parse_result_type want;
         while (due_results.size() != 0) begin
            want = due_results.pop_front();
            $display("%0t missing result: expected %s, got none",
                     $time, $sformatf("kind=%0d field=%0d byte=%02h len=%0d blank=%0d",
                     want.kind, want.field, want.vbyte, want.hlen, want.blank));
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   nhfp_req_if               req_ch();
   nhfp_rsp_if #(.LEN_W(13)) rsp_ch();
   nhfp_csr_if               csr_ch();

   news_header_field_parser #(
      .MAX_HEADER_BYTES(SAT_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   header_field_tracker tracker;
   parse_result_type    seen;
   int unsigned         quiet_cycles = 0;
   int unsigned         req_idle_pct = 12;
   int unsigned         rsp_idle_pct = 78;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind = kind_type'(rsp_ch.item_kind);
            seen.field = rsp_ch.field_id;
            seen.vbyte = rsp_ch.value_byte;
            seen.hlen = rsp_ch.header_length;
            seen.blank = rsp_ch.blank_line_found;
            tracker.check_result(seen);
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.accept_byte(req_ch.data_byte, req_ch.end_of_data);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic void put(ref hdr_byte_type q[$], input logic [7:0] b,
                               input logic eod = 1'b0);
      hdr_byte_type item;
      item.data = b;
      item.eod = eod;
      q.push_back(item);
   endfunction

   function automatic void put_text(ref hdr_byte_type q[$], input string s);
      for (int i = 0; i < s.len(); i++) put(q, 8'(s[i]));
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(5))
         0: return CH_TAB;
         1: return CH_VT;
         2: return CH_FF;
         3: return CH_CR;
         default: return CH_SP;
      endcase
   endfunction

   function automatic void put_value(ref hdr_byte_type q[$], input int unsigned n);
      logic [7:0] b;
      repeat (n) begin
         if ($urandom_range(15) == 0) begin
            b = 8'($urandom_range(255, 1));
            if (b == CH_LF) b = 8'hff;
         end else begin
            b = 8'($urandom_range(126, 32));
         end
         put(q, b);
      end
   endfunction

   // mixed-case field name with its colon
   function automatic void put_name(ref hdr_byte_type q[$], input int unsigned idx);
      logic [7:0] c;
      for (int i = 0; i < field_names[idx].len(); i++) begin
         c = 8'(field_names[idx][i]);
         if (c >= 8'h61 && c <= 8'h7a && $urandom_range(1) == 1) c = c - CASE_OFFSET;
         put(q, c);
      end
   endfunction

   function automatic void build_header(ref hdr_byte_type q[$], input bit huge);
      int unsigned lines;
      int unsigned sort;
      int unsigned k;
      q.delete();
      lines = huge ? 1 : $urandom_range(6);
      repeat (lines) begin
         sort = huge ? 0 : $urandom_range(99);
         if (sort >= 95) begin
            repeat ($urandom_range(10, 1)) put(q, 8'($urandom_range(255, 1)));
            put(q, CH_LF);
         end else begin
            if (sort >= 85) begin
               repeat ($urandom_range(6, 1)) put(q, 8'($urandom_range(122, 97)));
               put(q, ":");
               put(q, pick_blank());
               k = 3;
            end else begin
               if (sort >= 75) repeat ($urandom_range(2, 1)) put(q, CH_SP);
               if (huge) begin
                  put_name(q, 18);
               end else begin
                  put_name(q, ($urandom_range(3) == 0) ? $urandom_range(6, 4) :
                                                         $urandom_range(22));
               end
               k = huge ? 3 : $urandom_range(19);
               if (k == 0) begin
                  put(q, 8'($urandom_range(126, 33)));
               end else if (k >= 2) begin
                  repeat ($urandom_range(3, 1)) put(q, pick_blank());
               end
            end
            if (huge) begin
               put_value(q, LONG_VALUE);
            end else if (k == 0 || k >= 3) begin
               put_value(q, $urandom_range(10));
            end
            // folded continuation lines
            while ($urandom_range(3) == 0) begin
               put(q, CH_LF);
               put(q, pick_blank());
               put_value(q, $urandom_range(6));
            end
            put(q, CH_LF);
         end
      end
      k = $urandom_range(19);
      if (k < 2) begin
         put(q, CH_NUL);
      end else if (k < 4) begin
         put(q, 8'($urandom_range(255)), 1'b1);
      end else if (k == 4 && q.size() != 0) begin
         void'(q.pop_back());
         put(q, 8'($urandom_range(255)), 1'b1);
      end else begin
         put(q, CH_LF);
      end
   endfunction

   task automatic send_request(hdr_byte_type item);
      @(negedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= item.data;
      req_ch.end_of_data <= item.eod;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_seq(ref hdr_byte_type q[$]);
      foreach (q[i]) send_request(q[i]);
   endtask

   task automatic write_csr(csr_reg_type r, logic v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= r;
      csr_ch.wdata <= v;
      do @(posedge clock); while (!csr_ch.ready);
      tracker.set_reg(r, v);
   endtask

   // stop sending, then wait until every predicted result has come out
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      hdr_byte_type seq[$];
      int unsigned  sent;
      tracker = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.end_of_data = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = '0;
      csr_ch.wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // double space at line start, mixed case, 0xff value, fold, terminator mid-value,
      // single space at line start, blank line, bare NUL
      put_text(seq, "  xREF: ");
      put(seq, 8'hff);
      put_text(seq, "\n\tz");
      put(seq, 8'hff, 1'b1);
      put_text(seq, " Date: q\n\n");
      put(seq, CH_NUL);
      send_seq(seq);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(REG_ALL_FIELDS, ALL_SEQ[ph]);
         write_csr(REG_UPPER_D_ONLY, DATE_SEQ[ph]);
         @(negedge clock);
         csr_ch.valid <= 1'b0;
         req_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 78 : 0;
         rsp_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 12 : 0;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_header(seq, 1'b0);
            send_seq(seq);
            sent += seq.size();
         end
      end

      drain();
      tracker.flush_missing();
      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
